### design/kmds_pkg.sv
package kmds_pkg;

   localparam int ROW_COUNT    = 8;
   localparam int COLUMN_COUNT = 18;

   localparam int COL_W   = 5;
   localparam int ROW_W   = 8;
   localparam int DRIVE_W = 6;
   localparam int DELAY_W = 8;
   localparam int COUNT_W = 8;
   localparam int PC_W    = 4;

   localparam logic [ROW_W-1:0]   ROW_MASK     = ROW_W'((1 << ROW_COUNT) - 1);
   localparam logic [DELAY_W-1:0] DELAY_RESET  = DELAY_W'(5);
   localparam logic [DELAY_W-1:0] DELAY_MIN    = DELAY_W'(1);
   localparam logic [COL_W-1:0]   LAST_COL_IDX = COL_W'(COLUMN_COUNT - 1);
   localparam logic [COUNT_W-1:0] KEY_TOTAL    = COUNT_W'(ROW_COUNT * COLUMN_COUNT);

   // column drive table, one byte per column
   localparam logic [7:0] DRIVE_TABLE [COLUMN_COUNT] = '{
      8'h3A, 8'h58, 8'h70, 8'h6E, 8'h6C, 8'h6A, 8'h68, 8'h64, 8'h60,
      8'h62, 8'h1A, 8'h18, 8'h3C, 8'h66, 8'h38, 8'h72, 8'h1E, 8'h3E
   };

   typedef struct packed {
      logic [COL_W-1:0] column;
      logic [ROW_W-1:0] row_pins;
      logic             last_column;
   } item_type;

   typedef struct packed {
      logic [COUNT_W-1:0] raw_count;
      logic [COUNT_W-1:0] stable_count;
      logic [DELAY_W-1:0] countdown;
   } core_status_type;

   function automatic logic [DRIVE_W-1:0] drive_code(input logic [COL_W-1:0] idx);
      logic [7:0] entry;
      entry = DRIVE_TABLE[idx];
      return entry[DRIVE_W:1];
   endfunction

   function automatic logic [PC_W-1:0] popcount(input logic [ROW_W-1:0] v);
      logic [PC_W-1:0] n;
      n = '0;
      for (int i = 0; i < ROW_W; i++) begin
         n = n + PC_W'(v[i]);
      end
      return n;
   endfunction

endpackage

### design/kmds_in_stage.sv
module kmds_in_stage (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  kmds_pkg::item_type  req_item,
   input  logic                take,
   output logic                item_valid,
   output kmds_pkg::item_type  item
);
   import kmds_pkg::*;

   logic     valid_ff, valid_in;
   item_type item_ff, item_in;
   logic     load;

   assign req_stall = valid_ff && !take;
   assign load      = req_valid && !req_stall;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (load) begin
         valid_in = 1'b1;
         item_in  = req_item;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

### design/kmds_scan_core.sv
module kmds_scan_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               item_valid,
   input  kmds_pkg::item_type                 item,
   output logic                               take,
   input  logic [kmds_pkg::DELAY_W-1:0]       delay,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [kmds_pkg::DRIVE_W-1:0]       rsp_next_drive_code,
   output logic [kmds_pkg::ROW_W-1:0]         rsp_stable_column_bits,
   output logic                               rsp_settled,
   output logic [kmds_pkg::COUNT_W-1:0]       rsp_pressed_count,
   output kmds_pkg::core_status_type          status
);
   import kmds_pkg::*;

   logic [ROW_W-1:0]   raw_ff    [COLUMN_COUNT];
   logic [ROW_W-1:0]   raw_in    [COLUMN_COUNT];
   logic [ROW_W-1:0]   stable_ff [COLUMN_COUNT];
   logic [ROW_W-1:0]   stable_in [COLUMN_COUNT];
   logic [DELAY_W-1:0] countdown_ff, countdown_in;
   logic [COUNT_W-1:0] raw_count_ff, raw_count_in;
   logic [COUNT_W-1:0] stable_count_ff, stable_count_in;

   logic               valid_ff, valid_in;
   logic [DRIVE_W-1:0] drive_ff, drive_in;
   logic [ROW_W-1:0]   bits_ff, bits_in;
   logic               settled_ff, settled_in;
   logic [COUNT_W-1:0] count_ff, count_in;

   logic               fire;
   logic               col_ok;
   logic [ROW_W-1:0]   pressed;
   logic [ROW_W-1:0]   raw_old;
   logic [ROW_W-1:0]   stable_old;
   logic               change;
   logic [DELAY_W-1:0] cd_reload;
   logic               copy;
   logic [COL_W-1:0]   next_col;

   assign take = !valid_ff || !rsp_stall;
   assign fire = item_valid && take;

   assign col_ok     = item.column < COL_W'(COLUMN_COUNT);
   assign pressed    = ~item.row_pins & ROW_MASK;
   assign raw_old    = col_ok ? raw_ff[item.column] : '0;
   assign stable_old = col_ok ? stable_ff[item.column] : '0;
   assign change     = col_ok && (pressed != raw_old);
   assign cd_reload  = change ? delay : countdown_ff;
   assign next_col   = (col_ok && item.column != LAST_COL_IDX) ? item.column + COL_W'(1) : '0;

   always_comb begin
      countdown_in = cd_reload;
      copy         = 1'b0;
      if (item.last_column && cd_reload != '0) begin
         countdown_in = cd_reload - DELAY_W'(1);
         copy         = (countdown_in == '0);
      end
   end

   // raw count tracks the image incrementally, the stable count follows on copy
   assign raw_count_in = change ? raw_count_ff + COUNT_W'(popcount(pressed))
                                  - COUNT_W'(popcount(raw_old))
                                : raw_count_ff;
   assign stable_count_in = copy ? raw_count_in : stable_count_ff;

   always_comb begin
      for (int i = 0; i < COLUMN_COUNT; i++) begin
         raw_in[i] = (change && item.column == COL_W'(i)) ? pressed : raw_ff[i];
         stable_in[i] = copy ? raw_in[i] : stable_ff[i];
      end
   end

   always_comb begin
      drive_in   = drive_code(next_col);
      bits_in    = !col_ok ? '0 : (copy ? pressed : stable_old);
      settled_in = (countdown_in == '0);
      count_in   = stable_count_in;
      valid_in   = fire ? 1'b1 : (rsp_stall ? valid_ff : 1'b0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff        <= 1'b0;
         countdown_ff    <= DELAY_RESET;
         raw_count_ff    <= '0;
         stable_count_ff <= '0;
         for (int i = 0; i < COLUMN_COUNT; i++) begin
            raw_ff[i]    <= '0;
            stable_ff[i] <= '0;
         end
      end else begin
         valid_ff <= valid_in;
         if (fire) begin
            countdown_ff    <= countdown_in;
            raw_count_ff    <= raw_count_in;
            stable_count_ff <= stable_count_in;
            for (int i = 0; i < COLUMN_COUNT; i++) begin
               raw_ff[i]    <= raw_in[i];
               stable_ff[i] <= stable_in[i];
            end
         end
      end
      if (fire) begin
         drive_ff   <= drive_in;
         bits_ff    <= bits_in;
         settled_ff <= settled_in;
         count_ff   <= count_in;
      end
   end

   assign rsp_valid              = valid_ff;
   assign rsp_next_drive_code    = drive_ff;
   assign rsp_stable_column_bits = bits_ff;
   assign rsp_settled            = settled_ff;
   assign rsp_pressed_count      = count_ff;

   assign status.raw_count    = raw_count_ff;
   assign status.stable_count = stable_count_ff;
   assign status.countdown    = countdown_ff;

endmodule

### design/keyboard_matrix_debounce_scanner_top.sv
// channel | direction | handshake              | word
// req     | in        | req_valid / req_stall  | column, row_pins, last_column
// rsp     | out       | rsp_valid / rsp_stall  | next_drive_code, stable_column_bits,
//         |           |                        | settled, pressed_count
// csr     | in        | csr_valid / csr_ready  | debounce_delay (8 bits)
//
// one word per cycle sustained while rsp_stall stays low; an accepted word passes
// through the input register, then the scan core's result register
// reset is synchronous: images clear, delay and countdown load 5
// req_stall rises only when the input register is full and the result
// register is held by rsp_stall; csr_ready is always high
module keyboard_matrix_debounce_scanner_top (
   input  logic                               clock,
   input  logic                               reset,
   // item input
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [kmds_pkg::COL_W-1:0]         req_column,
   input  logic [kmds_pkg::ROW_W-1:0]         req_row_pins,
   input  logic                               req_last_column,
   // result output
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [kmds_pkg::DRIVE_W-1:0]       rsp_next_drive_code,
   output logic [kmds_pkg::ROW_W-1:0]         rsp_stable_column_bits,
   output logic                               rsp_settled,
   output logic [kmds_pkg::COUNT_W-1:0]       rsp_pressed_count,
   // debounce delay register
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [kmds_pkg::DELAY_W-1:0]       csr_data
);
   import kmds_pkg::*;

   item_type           req_item;
   item_type           s1_item;
   logic               s1_valid;
   logic               take;
   core_status_type    status;
   logic [DELAY_W-1:0] delay_ff, delay_in;

   // a write of zero saturates to the low bound so the image never freezes
   assign csr_ready = 1'b1;
   assign delay_in  = (csr_valid && csr_ready) ?
                      ((csr_data == '0) ? DELAY_MIN : csr_data) : delay_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ff <= DELAY_RESET;
      end else begin
         delay_ff <= delay_in;
      end
   end

   assign req_item.column      = req_column;
   assign req_item.row_pins    = req_row_pins;
   assign req_item.last_column = req_last_column;

   // input register
   kmds_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_item   (req_item),
      .take       (take),
      .item_valid (s1_valid),
      .item       (s1_item)
   );

   // image update, countdown and result register
   kmds_scan_core u_scan_core (
      .clock                  (clock),
      .reset                  (reset),
      .item_valid             (s1_valid),
      .item                   (s1_item),
      .take                   (take),
      .delay                  (delay_ff),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_next_drive_code    (rsp_next_drive_code),
      .rsp_stable_column_bits (rsp_stable_column_bits),
      .rsp_settled            (rsp_settled),
      .rsp_pressed_count      (rsp_pressed_count),
      .status                 (status)
   );

   // stall only when the input register holds a word that cannot move on
   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid && rsp_valid && rsp_stall))
      else $error("req_stall without a blocked word");

   a_delay_nonzero: assert property (@(posedge clock) disable iff (reset)
      delay_ff != '0)
      else $error("debounce delay is zero");

   a_counts_bounded: assert property (@(posedge clock) disable iff (reset)
      (status.raw_count <= KEY_TOTAL) && (status.stable_count <= KEY_TOTAL))
      else $error("key count out of range");

   // settled flag of a fresh result reflects the countdown it left behind
   a_settled_matches: assert property (@(posedge clock) disable iff (reset)
      (s1_valid && take) |=> (rsp_settled == (status.countdown == '0)))
      else $error("settled flag disagrees with countdown");

endmodule
